FILE: design/bsge_pkg.sv
// bsge_pkg: shared types and codes for the banker's safe grant engine
// holds request type codes, status codes, parameter defaults and the sequencer state type
// no dependencies

package bsge_pkg;

    // parameter defaults
    localparam int DEF_MAX_CLIENTS   = 16;
    localparam int DEF_MAX_RESOURCES = 8;
    localparam int DEF_UNIT_WIDTH    = 16;

    // field widths fixed by the interface
    localparam int REQ_TYPE_W   = 3;
    localparam int CLIENT_IDX_W = 4;
    localparam int RES_IDX_W    = 3;
    localparam int VALUE_W      = 16;
    localparam int STATUS_W     = 4;
    localparam int CFG_DATA_W   = 5;

    // configuration register indexes
    localparam logic CFG_CLIENT_COUNT   = 1'b0;
    localparam logic CFG_RESOURCE_COUNT = 1'b1;

    // request types
    localparam logic [REQ_TYPE_W-1:0] REQ_SET_TOTAL = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_SET_MAX   = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_SET_ALLOC = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_ELEMENT   = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_QUERY     = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_LOADED   = 4'd0;
    localparam logic [STATUS_W-1:0] ST_STORED   = 4'd1;
    localparam logic [STATUS_W-1:0] ST_GRANTED  = 4'd2;
    localparam logic [STATUS_W-1:0] ST_OVER_MAX = 4'd3;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 4'd4;
    localparam logic [STATUS_W-1:0] ST_ROLLBACK = 4'd5;
    localparam logic [STATUS_W-1:0] ST_SAFE     = 4'd6;
    localparam logic [STATUS_W-1:0] ST_UNSAFE   = 4'd7;
    localparam logic [STATUS_W-1:0] ST_BAD_IDX  = 4'd8;

    // sequencer states
    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_RC_INIT,
        S_RC_RD,
        S_RC_SUB,
        S_RC_WR,
        S_DISPATCH,
        S_TOT_SUB,
        S_TOT_ADD,
        S_LAL_SUB,
        S_LAL_ADD,
        S_CHK_RD,
        S_CHK_NEED,
        S_CHK_OVER,
        S_CHK_AVAIL,
        S_CHK_END,
        S_APPLY_RD,
        S_APPLY_ALLOC,
        S_APPLY_AVAIL,
        S_SAFE_INIT,
        S_SAFE_CLIENT,
        S_SAFE_RD,
        S_SAFE_NEED,
        S_SAFE_CMP,
        S_SAFE_RET_RD,
        S_SAFE_RET,
        S_SAFE_END,
        S_UNDO_RD,
        S_UNDO_ALLOC,
        S_UNDO_AVAIL,
        S_RESP
    } state_t;

endpackage

FILE: design/bankers_safe_grant_engine.sv
// bankers_safe_grant_engine: deadlock-avoidance allocator with a greedy safety check
// one shared add/subtract unit under a sequencer; maximum and allocation tables in memories
// depends on bsge_pkg

// Each request returns exactly one status. A load of a total or an allocation entry
// adjusts the available count with a subtract and an add step; a maximum load or a plain
// request element goes straight to the response. A request vector's last element runs a
// check over the resources in use (read, need, over-maximum and availability steps each),
// a trial apply (read, allocation write and availability update each) and the safety
// pass; a safety query runs the pass alone. The pass visits every unfinished client once
// per round, testing its need per resource (read, need, compare) and, if it fits,
// returning its allocation per resource (read, add), and repeats rounds while some client
// finishes. A rolled back request adds a read, allocation write and availability update
// per resource. All table accesses go through one read port per table with registered
// read data, and every sum or compare through a single adder. After reset the block clears
// both tables, one entry a cycle over the next power of two of MAX_CLIENTS times the next
// power of two of MAX_RESOURCES entries (128 by default), before it takes a request. A
// configuration write recomputes the available counts, during which no request is taken.

module bankers_safe_grant_engine #(
    parameter int MAX_CLIENTS   = bsge_pkg::DEF_MAX_CLIENTS,
    parameter int MAX_RESOURCES = bsge_pkg::DEF_MAX_RESOURCES,
    parameter int UNIT_WIDTH    = bsge_pkg::DEF_UNIT_WIDTH
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [bsge_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bsge_pkg::REQ_TYPE_W-1:0]   s_req_type,
    input  logic [bsge_pkg::CLIENT_IDX_W-1:0] s_client_index,
    input  logic [bsge_pkg::RES_IDX_W-1:0]    s_resource_index,
    input  logic [bsge_pkg::VALUE_W-1:0]      s_value,
    input  logic                              s_last,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bsge_pkg::STATUS_W-1:0]     m_status
);

    localparam int CIW = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
    localparam int RIW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int CCW = $clog2(MAX_CLIENTS + 1);
    localparam int RCW = $clog2(MAX_RESOURCES + 1);
    localparam int CMW = (CCW > bsge_pkg::CLIENT_IDX_W) ? CCW : bsge_pkg::CLIENT_IDX_W;
    localparam int RMW = (RCW > bsge_pkg::RES_IDX_W) ? RCW : bsge_pkg::RES_IDX_W;
    localparam int AW  = CIW + RIW;
    localparam int MEM_DEPTH = 1 << AW;
    localparam int AVW = UNIT_WIDTH + $clog2(MAX_CLIENTS) + 2;
    localparam int DW  = AVW + 1;
    localparam int CC_RESET = (MAX_CLIENTS < 16) ? MAX_CLIENTS : 16;
    localparam int RC_RESET = (MAX_RESOURCES < 8) ? MAX_RESOURCES : 8;

    bsge_pkg::state_t state_reg, state_next;

    // configuration
    logic [CCW-1:0] cc_reg;
    logic [RCW-1:0] rc_reg;
    logic           recalc_pend_reg;

    // latched request
    logic [bsge_pkg::REQ_TYPE_W-1:0]   item_type_reg;
    logic [bsge_pkg::CLIENT_IDX_W-1:0] item_c_reg;
    logic [bsge_pkg::RES_IDX_W-1:0]    item_r_reg;
    logic [UNIT_WIDTH-1:0]             item_v_reg;
    logic                              item_last_reg;

    // resource state
    logic [UNIT_WIDTH-1:0]        total_reg [MAX_RESOURCES];
    logic signed [AVW-1:0]        avail_reg [MAX_RESOURCES];
    logic signed [AVW-1:0]        work_reg  [MAX_RESOURCES];
    logic [UNIT_WIDTH-1:0]        buf_reg   [MAX_RESOURCES];
    logic [CIW-1:0]               req_client_reg;
    logic [MAX_CLIENTS-1:0]       fin_reg;

    // sequencer scratch
    logic [CCW-1:0]        c_reg;
    logic [RCW-1:0]        r_reg;
    logic [AW-1:0]         clr_reg;
    logic signed [DW-1:0]  tmp_reg;
    logic                  over_reg;
    logic                  short_reg;
    logic                  fits_reg;
    logic                  progress_reg;
    logic [bsge_pkg::STATUS_W-1:0] status_reg;

    // output register
    logic                          m_valid_reg;
    logic [bsge_pkg::STATUS_W-1:0] m_status_reg;

    // tables
    logic [UNIT_WIDTH-1:0] max_mem   [MEM_DEPTH];
    logic [UNIT_WIDTH-1:0] alloc_mem [MEM_DEPTH];
    logic [UNIT_WIDTH-1:0] max_q_reg;
    logic [UNIT_WIDTH-1:0] alloc_q_reg;

    logic [AW-1:0]         mem_addr;
    logic                  max_we;
    logic                  alloc_we;
    logic [UNIT_WIDTH-1:0] max_wdata;
    logic [UNIT_WIDTH-1:0] alloc_wdata;

    // shared adder
    logic signed [DW-1:0] alu_a, alu_b, alu_res;
    logic                 alu_sub;
    logic                 alu_neg;

    // decode helpers
    logic [CMW-1:0]  item_c_ext;
    logic [RMW-1:0]  item_r_ext;
    logic            ok_c, ok_r;
    logic [RIW-1:0]  r_sel;
    logic [RCW-1:0]  r_inc;
    logic [CCW-1:0]  c_inc;
    logic            r_last;
    logic            rc_last;
    logic            c_end;
    logic [MAX_CLIENTS-1:0] act_mask;
    logic            all_done;
    logic            fits_now;
    logic            out_free;
    logic            accept;
    logic [31:0]     value_ext;

    assign item_c_ext = CMW'(item_c_reg);
    assign item_r_ext = RMW'(item_r_reg);
    assign ok_c       = item_c_ext < CMW'(cc_reg);
    assign ok_r       = item_r_ext < RMW'(rc_reg);
    assign r_inc      = r_reg + RCW'(1);
    assign c_inc      = c_reg + CCW'(1);
    assign r_last     = (r_inc == rc_reg);
    assign rc_last    = (r_inc == RCW'(MAX_RESOURCES));
    assign c_end      = (c_reg == cc_reg);
    assign fits_now   = fits_reg && !alu_neg;
    assign out_free   = !m_valid_reg || m_ready;
    assign value_ext  = 32'(s_value);

    assign s_ready = (state_reg == bsge_pkg::S_IDLE) && !recalc_pend_reg && !cfg_we;
    assign accept  = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;

    // clients in use as a mask
    always_comb begin
        for (int i = 0; i < MAX_CLIENTS; i++) begin
            act_mask[i] = (CCW'(i) < cc_reg);
        end
    end
    assign all_done = &(fin_reg | ~act_mask);

    // resource index: item field for loads, counter for sweeps
    always_comb begin
        unique case (state_reg)
            bsge_pkg::S_TOT_SUB, bsge_pkg::S_TOT_ADD,
            bsge_pkg::S_LAL_SUB, bsge_pkg::S_LAL_ADD,
            bsge_pkg::S_DISPATCH:
                r_sel = item_r_ext[RIW-1:0];
            default:
                r_sel = r_reg[RIW-1:0];
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bsge_pkg::S_CLEAR: begin
                if (clr_reg == '1) state_next = bsge_pkg::S_IDLE;
            end
            bsge_pkg::S_IDLE: begin
                if (recalc_pend_reg) state_next = bsge_pkg::S_RC_INIT;
                else if (accept) state_next = bsge_pkg::S_DISPATCH;
            end
            bsge_pkg::S_RC_INIT: state_next = bsge_pkg::S_RC_RD;
            bsge_pkg::S_RC_RD: begin
                state_next = c_end ? bsge_pkg::S_RC_WR : bsge_pkg::S_RC_SUB;
            end
            bsge_pkg::S_RC_SUB: state_next = bsge_pkg::S_RC_RD;
            bsge_pkg::S_RC_WR: begin
                state_next = rc_last ? bsge_pkg::S_IDLE : bsge_pkg::S_RC_INIT;
            end
            bsge_pkg::S_DISPATCH: begin
                state_next = bsge_pkg::S_RESP;
                case (item_type_reg)
                    bsge_pkg::REQ_SET_TOTAL: begin
                        if (ok_r) state_next = bsge_pkg::S_TOT_SUB;
                    end
                    bsge_pkg::REQ_SET_ALLOC: begin
                        if (ok_c && ok_r) state_next = bsge_pkg::S_LAL_SUB;
                    end
                    bsge_pkg::REQ_ELEMENT: begin
                        if (ok_c && ok_r && item_last_reg) state_next = bsge_pkg::S_CHK_RD;
                    end
                    bsge_pkg::REQ_QUERY: state_next = bsge_pkg::S_SAFE_INIT;
                    default: state_next = bsge_pkg::S_RESP;
                endcase
            end
            bsge_pkg::S_TOT_SUB:  state_next = bsge_pkg::S_TOT_ADD;
            bsge_pkg::S_TOT_ADD:  state_next = bsge_pkg::S_RESP;
            bsge_pkg::S_LAL_SUB:  state_next = bsge_pkg::S_LAL_ADD;
            bsge_pkg::S_LAL_ADD:  state_next = bsge_pkg::S_RESP;
            bsge_pkg::S_CHK_RD:   state_next = bsge_pkg::S_CHK_NEED;
            bsge_pkg::S_CHK_NEED: state_next = bsge_pkg::S_CHK_OVER;
            bsge_pkg::S_CHK_OVER: state_next = bsge_pkg::S_CHK_AVAIL;
            bsge_pkg::S_CHK_AVAIL: begin
                state_next = r_last ? bsge_pkg::S_CHK_END : bsge_pkg::S_CHK_RD;
            end
            bsge_pkg::S_CHK_END: begin
                state_next = (over_reg || short_reg) ? bsge_pkg::S_RESP
                                                     : bsge_pkg::S_APPLY_RD;
            end
            bsge_pkg::S_APPLY_RD:    state_next = bsge_pkg::S_APPLY_ALLOC;
            bsge_pkg::S_APPLY_ALLOC: state_next = bsge_pkg::S_APPLY_AVAIL;
            bsge_pkg::S_APPLY_AVAIL: begin
                state_next = r_last ? bsge_pkg::S_SAFE_INIT : bsge_pkg::S_APPLY_RD;
            end
            bsge_pkg::S_SAFE_INIT: state_next = bsge_pkg::S_SAFE_CLIENT;
            bsge_pkg::S_SAFE_CLIENT: begin
                if (c_end) begin
                    state_next = progress_reg ? bsge_pkg::S_SAFE_CLIENT : bsge_pkg::S_SAFE_END;
                end else if (!fin_reg[c_reg[CIW-1:0]]) begin
                    state_next = bsge_pkg::S_SAFE_RD;
                end
            end
            bsge_pkg::S_SAFE_RD:   state_next = bsge_pkg::S_SAFE_NEED;
            bsge_pkg::S_SAFE_NEED: state_next = bsge_pkg::S_SAFE_CMP;
            bsge_pkg::S_SAFE_CMP: begin
                if (!r_last) state_next = bsge_pkg::S_SAFE_RD;
                else if (fits_now) state_next = bsge_pkg::S_SAFE_RET_RD;
                else state_next = bsge_pkg::S_SAFE_CLIENT;
            end
            bsge_pkg::S_SAFE_RET_RD: state_next = bsge_pkg::S_SAFE_RET;
            bsge_pkg::S_SAFE_RET: begin
                state_next = r_last ? bsge_pkg::S_SAFE_CLIENT : bsge_pkg::S_SAFE_RET_RD;
            end
            bsge_pkg::S_SAFE_END: begin
                if (item_type_reg == bsge_pkg::REQ_QUERY || all_done)
                    state_next = bsge_pkg::S_RESP;
                else
                    state_next = bsge_pkg::S_UNDO_RD;
            end
            bsge_pkg::S_UNDO_RD:    state_next = bsge_pkg::S_UNDO_ALLOC;
            bsge_pkg::S_UNDO_ALLOC: state_next = bsge_pkg::S_UNDO_AVAIL;
            bsge_pkg::S_UNDO_AVAIL: begin
                state_next = r_last ? bsge_pkg::S_RESP : bsge_pkg::S_UNDO_RD;
            end
            bsge_pkg::S_RESP: begin
                if (out_free) state_next = bsge_pkg::S_IDLE;
            end
            default: state_next = bsge_pkg::S_IDLE;
        endcase
    end

    // adder operands, table address and write strobes
    always_comb begin
        alu_a       = '0;
        alu_b       = '0;
        alu_sub     = 1'b0;
        mem_addr    = {item_c_ext[CIW-1:0], item_r_ext[RIW-1:0]};
        max_we      = 1'b0;
        alloc_we    = 1'b0;
        max_wdata   = item_v_reg;
        alloc_wdata = item_v_reg;
        unique case (state_reg)
            bsge_pkg::S_CLEAR: begin
                mem_addr    = clr_reg;
                max_we      = 1'b1;
                alloc_we    = 1'b1;
                max_wdata   = '0;
                alloc_wdata = '0;
            end
            bsge_pkg::S_RC_INIT: begin
                alu_a = DW'(total_reg[r_sel]);
            end
            bsge_pkg::S_RC_RD: begin
                mem_addr = {c_reg[CIW-1:0], r_sel};
            end
            bsge_pkg::S_RC_SUB: begin
                mem_addr = {c_reg[CIW-1:0], r_sel};
                alu_a    = tmp_reg;
                alu_b    = DW'(alloc_q_reg);
                alu_sub  = 1'b1;
            end
            bsge_pkg::S_DISPATCH: begin
                max_we = (item_type_reg == bsge_pkg::REQ_SET_MAX) && ok_c && ok_r;
            end
            bsge_pkg::S_TOT_SUB: begin
                alu_a   = DW'(item_v_reg);
                alu_b   = DW'(total_reg[r_sel]);
                alu_sub = 1'b1;
            end
            bsge_pkg::S_TOT_ADD, bsge_pkg::S_LAL_ADD: begin
                alu_a = DW'(avail_reg[r_sel]);
                alu_b = tmp_reg;
            end
            bsge_pkg::S_LAL_SUB: begin
                alloc_we = 1'b1;
                alu_a    = DW'(alloc_q_reg);
                alu_b    = DW'(item_v_reg);
                alu_sub  = 1'b1;
            end
            bsge_pkg::S_CHK_RD, bsge_pkg::S_APPLY_RD, bsge_pkg::S_UNDO_RD: begin
                mem_addr = {req_client_reg, r_sel};
            end
            bsge_pkg::S_CHK_NEED: begin
                mem_addr = {req_client_reg, r_sel};
                alu_a    = DW'(max_q_reg);
                alu_b    = DW'(alloc_q_reg);
                alu_sub  = 1'b1;
            end
            bsge_pkg::S_CHK_OVER: begin
                mem_addr = {req_client_reg, r_sel};
                alu_a    = tmp_reg;
                alu_b    = DW'(buf_reg[r_sel]);
                alu_sub  = 1'b1;
            end
            bsge_pkg::S_CHK_AVAIL, bsge_pkg::S_APPLY_AVAIL: begin
                mem_addr = {req_client_reg, r_sel};
                alu_a    = DW'(avail_reg[r_sel]);
                alu_b    = DW'(buf_reg[r_sel]);
                alu_sub  = 1'b1;
            end
            bsge_pkg::S_APPLY_ALLOC: begin
                mem_addr    = {req_client_reg, r_sel};
                alu_a       = DW'(alloc_q_reg);
                alu_b       = DW'(buf_reg[r_sel]);
                alloc_we    = 1'b1;
                alloc_wdata = alu_res[UNIT_WIDTH-1:0];
            end
            bsge_pkg::S_UNDO_ALLOC: begin
                mem_addr    = {req_client_reg, r_sel};
                alu_a       = DW'(alloc_q_reg);
                alu_b       = DW'(buf_reg[r_sel]);
                alu_sub     = 1'b1;
                alloc_we    = 1'b1;
                alloc_wdata = alu_res[UNIT_WIDTH-1:0];
            end
            bsge_pkg::S_UNDO_AVAIL: begin
                mem_addr = {req_client_reg, r_sel};
                alu_a    = DW'(avail_reg[r_sel]);
                alu_b    = DW'(buf_reg[r_sel]);
            end
            bsge_pkg::S_SAFE_RD, bsge_pkg::S_SAFE_RET_RD: begin
                mem_addr = {c_reg[CIW-1:0], r_sel};
            end
            bsge_pkg::S_SAFE_NEED: begin
                mem_addr = {c_reg[CIW-1:0], r_sel};
                alu_a    = DW'(max_q_reg);
                alu_b    = DW'(alloc_q_reg);
                alu_sub  = 1'b1;
            end
            bsge_pkg::S_SAFE_CMP: begin
                mem_addr = {c_reg[CIW-1:0], r_sel};
                alu_a    = DW'(work_reg[r_sel]);
                alu_b    = tmp_reg;
                alu_sub  = 1'b1;
            end
            bsge_pkg::S_SAFE_RET: begin
                mem_addr = {c_reg[CIW-1:0], r_sel};
                alu_a    = DW'(work_reg[r_sel]);
                alu_b    = DW'(alloc_q_reg);
            end
            default: begin
                alu_a = '0;
            end
        endcase
    end

    // the one shared add/subtract unit
    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign alu_neg = alu_res[DW-1];

    // maximum and allocation tables, registered read
    always_ff @(posedge aclk) begin
        if (max_we) max_mem[mem_addr] <= max_wdata;
        if (alloc_we) alloc_mem[mem_addr] <= alloc_wdata;
        max_q_reg   <= max_mem[mem_addr];
        alloc_q_reg <= alloc_mem[mem_addr];
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= bsge_pkg::S_CLEAR;
        else state_reg <= state_next;
    end

    // configuration registers and recompute request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg          <= CCW'(CC_RESET);
            rc_reg          <= RCW'(RC_RESET);
            recalc_pend_reg <= 1'b0;
        end else begin
            if (state_reg == bsge_pkg::S_IDLE && recalc_pend_reg) recalc_pend_reg <= 1'b0;
            if (cfg_we) begin
                recalc_pend_reg <= 1'b1;
                if (cfg_index == bsge_pkg::CFG_CLIENT_COUNT) begin
                    if (cfg_data == '0) cc_reg <= CCW'(1);
                    else if (int'(cfg_data) > MAX_CLIENTS) cc_reg <= CCW'(MAX_CLIENTS);
                    else cc_reg <= CCW'(cfg_data);
                end else begin
                    if (cfg_data[3:0] == '0) rc_reg <= RCW'(1);
                    else if (int'(cfg_data[3:0]) > MAX_RESOURCES) rc_reg <= RCW'(MAX_RESOURCES);
                    else rc_reg <= RCW'(cfg_data[3:0]);
                end
            end
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_type_reg <= s_req_type;
            item_c_reg    <= s_client_index;
            item_r_reg    <= s_resource_index;
            item_v_reg    <= value_ext[UNIT_WIDTH-1:0];
            item_last_reg <= s_last;
        end
    end

    // sequencer datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg        <= '0;
            c_reg          <= '0;
            r_reg          <= '0;
            req_client_reg <= '0;
            fin_reg        <= '0;
            over_reg       <= 1'b0;
            short_reg      <= 1'b0;
            fits_reg       <= 1'b0;
            progress_reg   <= 1'b0;
            status_reg     <= bsge_pkg::ST_BAD_IDX;
            tmp_reg        <= '0;
            for (int i = 0; i < MAX_RESOURCES; i++) begin
                total_reg[i] <= '0;
                avail_reg[i] <= '0;
                buf_reg[i]   <= '0;
                work_reg[i]  <= '0;
            end
        end else begin
            case (state_reg)
                bsge_pkg::S_CLEAR: begin
                    clr_reg <= clr_reg + AW'(1);
                end
                bsge_pkg::S_IDLE: begin
                    r_reg <= '0;
                end
                bsge_pkg::S_RC_INIT: begin
                    tmp_reg <= alu_res;
                    c_reg   <= '0;
                end
                bsge_pkg::S_RC_SUB: begin
                    tmp_reg <= alu_res;
                    c_reg   <= c_inc;
                end
                bsge_pkg::S_RC_WR: begin
                    avail_reg[r_sel] <= AVW'(tmp_reg);
                    r_reg            <= r_inc;
                end
                bsge_pkg::S_DISPATCH: begin
                    status_reg <= bsge_pkg::ST_BAD_IDX;
                    r_reg      <= '0;
                    over_reg   <= 1'b0;
                    short_reg  <= 1'b0;
                    case (item_type_reg)
                        bsge_pkg::REQ_SET_TOTAL: begin
                            if (ok_r) status_reg <= bsge_pkg::ST_LOADED;
                        end
                        bsge_pkg::REQ_SET_MAX, bsge_pkg::REQ_SET_ALLOC: begin
                            if (ok_c && ok_r) status_reg <= bsge_pkg::ST_LOADED;
                        end
                        bsge_pkg::REQ_ELEMENT: begin
                            if (ok_c && ok_r) begin
                                req_client_reg   <= item_c_ext[CIW-1:0];
                                buf_reg[r_sel]   <= item_v_reg;
                                status_reg       <= bsge_pkg::ST_STORED;
                            end
                        end
                        default: status_reg <= bsge_pkg::ST_BAD_IDX;
                    endcase
                end
                bsge_pkg::S_TOT_SUB: begin
                    tmp_reg          <= alu_res;
                    total_reg[r_sel] <= item_v_reg;
                end
                bsge_pkg::S_LAL_SUB: begin
                    tmp_reg <= alu_res;
                end
                bsge_pkg::S_TOT_ADD, bsge_pkg::S_LAL_ADD, bsge_pkg::S_UNDO_AVAIL,
                bsge_pkg::S_APPLY_AVAIL: begin
                    avail_reg[r_sel] <= AVW'(alu_res);
                    r_reg            <= r_inc;
                    if (state_reg == bsge_pkg::S_UNDO_AVAIL && r_last) begin
                        status_reg <= bsge_pkg::ST_ROLLBACK;
                        for (int i = 0; i < MAX_RESOURCES; i++) buf_reg[i] <= '0;
                    end
                    if (r_last) r_reg <= '0;
                end
                bsge_pkg::S_CHK_NEED, bsge_pkg::S_SAFE_NEED: begin
                    tmp_reg <= alu_res;
                end
                bsge_pkg::S_CHK_OVER: begin
                    if (alu_neg) over_reg <= 1'b1;
                end
                bsge_pkg::S_CHK_AVAIL: begin
                    if (alu_neg) short_reg <= 1'b1;
                    r_reg <= r_last ? '0 : r_inc;
                end
                bsge_pkg::S_CHK_END: begin
                    if (over_reg || short_reg) begin
                        status_reg <= over_reg ? bsge_pkg::ST_OVER_MAX : bsge_pkg::ST_SHORT;
                        for (int i = 0; i < MAX_RESOURCES; i++) buf_reg[i] <= '0;
                    end
                end
                bsge_pkg::S_SAFE_INIT: begin
                    for (int i = 0; i < MAX_RESOURCES; i++) work_reg[i] <= avail_reg[i];
                    fin_reg      <= '0;
                    c_reg        <= '0;
                    r_reg        <= '0;
                    progress_reg <= 1'b0;
                end
                bsge_pkg::S_SAFE_CLIENT: begin
                    r_reg    <= '0;
                    fits_reg <= 1'b1;
                    if (c_end) begin
                        c_reg        <= '0;
                        progress_reg <= 1'b0;
                    end else if (fin_reg[c_reg[CIW-1:0]]) begin
                        c_reg <= c_inc;
                    end
                end
                bsge_pkg::S_SAFE_CMP: begin
                    fits_reg <= fits_now;
                    if (r_last) begin
                        r_reg <= '0;
                        if (!fits_now) c_reg <= c_inc;
                    end else begin
                        r_reg <= r_inc;
                    end
                end
                bsge_pkg::S_SAFE_RET: begin
                    work_reg[r_sel] <= AVW'(alu_res);
                    if (r_last) begin
                        r_reg                   <= '0;
                        fin_reg[c_reg[CIW-1:0]] <= 1'b1;
                        progress_reg            <= 1'b1;
                        c_reg                   <= c_inc;
                    end else begin
                        r_reg <= r_inc;
                    end
                end
                bsge_pkg::S_SAFE_END: begin
                    r_reg <= '0;
                    if (item_type_reg == bsge_pkg::REQ_QUERY) begin
                        status_reg <= all_done ? bsge_pkg::ST_SAFE : bsge_pkg::ST_UNSAFE;
                    end else if (all_done) begin
                        status_reg <= bsge_pkg::ST_GRANTED;
                        for (int i = 0; i < MAX_RESOURCES; i++) buf_reg[i] <= '0;
                    end
                end
                default: begin
                    clr_reg <= clr_reg;
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            m_status_reg <= bsge_pkg::ST_LOADED;
        end else begin
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (state_reg == bsge_pkg::S_RESP && out_free) begin
                m_valid_reg  <= 1'b1;
                m_status_reg <= status_reg;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // one request at a time: ready drops right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("request taken while a request is in flight");

    // a register write always triggers an availability recompute before the next request
    a_cfg_recompute: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_ready)
        else $error("request window open right after a register write");

    // the safety pass never marks a client outside the count in use
    a_fin_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bsge_pkg::S_SAFE_END) |-> ((fin_reg & ~act_mask) == '0))
        else $error("finished flag set for a client not in use");

    // a result is only loaded from the response state
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == bsge_pkg::S_RESP))
        else $error("result raised outside the response step");
`endif

endmodule
